FILE: hw/rtl/blrs_pkg.sv
`timescale 1ns / 1ps

package blrs_pkg;

    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned POS_W     = 5;

    typedef enum logic [1:0] {
        MODE_APPEND  = 2'd0,
        MODE_REMOVE  = 2'd1,
        MODE_REVERSE = 2'd2,
        MODE_SEARCH  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_FULL     = 3'd1,
        ST_POPPED   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_REVERSED = 3'd4,
        ST_FOUND    = 3'd5,
        ST_NOTFOUND = 3'd6
    } t_status;

    typedef struct packed {
        t_status                   status;
        logic signed [VAL_W-1:0]   value_out;
        logic        [POS_W-1:0]   position;
        logic                      last;
    } t_rsp;

    function automatic t_rsp f_rsp(input t_status st, input logic signed [VAL_W-1:0] val,
                                   input logic [POS_W-1:0] pos, input logic lst);
        t_rsp r;
        r.status    = st;
        r.value_out = val;
        r.position  = pos;
        r.last      = lst;
        return r;
    endfunction

endpackage

FILE: hw/rtl/blrs_if.sv
`timescale 1ns / 1ps

interface blrs_req_if import blrs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic        [1:0]       mode;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface blrs_rsp_if import blrs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic        [2:0]       status;
    logic signed [VAL_W-1:0] value_out;
    logic        [POS_W-1:0] position;
    logic                    last;

    modport source (output valid, output status, output value_out, output position,
                    output last, input ready);
    modport sink   (input valid, input status, input value_out, input position,
                    input last, output ready);
endinterface

FILE: hw/rtl/blrs_mem.sv
`timescale 1ns / 1ps

module blrs_mem import blrs_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEF,
    parameter int unsigned AW    = 4
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic signed [VAL_W-1:0] i_wdata,
    input  logic                    i_re,
    input  logic [AW-1:0]           i_raddr,
    output logic signed [VAL_W-1:0] o_rdata
);

    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while i_re is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/blrs_out.sv
`timescale 1ns / 1ps

module blrs_out import blrs_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  t_rsp            i_data,
    output logic            o_can_load,
    blrs_rsp_if.source      o_rsp
);

    logic r_valid;
    t_rsp r_data;

    assign o_can_load = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_data <= i_data;
        end
    end

    assign o_rsp.valid     = r_valid;
    assign o_rsp.status    = r_data.status;
    assign o_rsp.value_out = r_data.value_out;
    assign o_rsp.position  = r_data.position;
    assign o_rsp.last      = r_data.last;

endmodule

FILE: hw/rtl/bounded_list_with_reverse_search.sv
// Append, reverse, full and empty: result registered, then loaded into the output register.
// Remove: one registered read of the store, then both registers. Search over N stored values:
// one store read and one compare per cycle while no earlier hit waits on the output register.
// Ready again in the cycle after the final result is loaded into the output register;
// a stalled result port holds it.
// Synchronous active-low reset empties the list and clears the reversed flag;
// store contents are not cleared.
`timescale 1ns / 1ps

module bounded_list_with_reverse_search import blrs_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    blrs_req_if.sink    i_req,
    blrs_rsp_if.source  o_rsp
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = AW + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_POP  = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                  r_state;
    logic [AW-1:0]           r_head;
    logic [CW-1:0]           r_count;
    logic                    r_rev;
    logic signed [VAL_W-1:0] r_key;
    logic [CW-1:0]           r_rd_pos;
    logic                    r_cmp_vld;
    logic [CW-1:0]           r_cmp_pos;
    logic                    r_pend;
    logic [CW-1:0]           r_pend_pos;
    t_rsp                    r_res;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [VAL_W-1:0] mem_wdata;
    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;
    logic signed [VAL_W-1:0] mem_rdata;

    logic                    out_load;
    t_rsp                    out_data;
    logic                    out_can_load;

    logic                    acc;
    logic                    full;
    logic                    empty;
    logic [AW-1:0]           head_dec;
    logic [AW-1:0]           head_inc;
    logic                    cmp_hit;
    logic                    stall;
    logic                    more;
    logic                    scan_done;
    logic [CW-1:0]           scan_off;

    // physical slot of (head + off) mod DEPTH, off below DEPTH
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign i_req.ready = (r_state == S_IDLE);
    assign acc         = i_req.valid && i_req.ready;
    assign full        = (r_count == CW'(DEPTH));
    assign empty       = (r_count == '0);
    assign head_dec    = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc    = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);

    // search: one read issued and one compare per cycle; a second hit waits
    // while the earlier one cannot be handed to the output register
    assign cmp_hit   = r_cmp_vld && (mem_rdata == r_key);
    assign stall     = cmp_hit && r_pend && !out_can_load;
    assign more      = (r_rd_pos < r_count);
    assign scan_done = !r_cmp_vld && !more;
    assign scan_off  = r_rev ? (r_count - CW'(1) - r_rd_pos) : r_rd_pos;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_rev ? head_dec : f_slot(r_head, r_count);
        mem_wdata = i_req.value;
        mem_re    = 1'b0;
        mem_raddr = f_slot(r_head, scan_off);
        out_load  = 1'b0;
        out_data  = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (acc && (i_req.mode == MODE_APPEND) && !full) begin
                    mem_we = 1'b1;
                end
                if (acc && (i_req.mode == MODE_REMOVE) && !empty) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_rev ? r_head : f_slot(r_head, r_count - CW'(1));
                end
            end
            S_POP: begin
            end
            S_SCAN: begin
                mem_re = !stall && more;
                if (cmp_hit && r_pend && out_can_load) begin
                    out_load = 1'b1;
                    out_data = f_rsp(ST_FOUND, '0, POS_W'(r_pend_pos), 1'b0);
                end
            end
            S_EMIT: begin
                out_load = out_can_load;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_rev     <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_key <= i_req.value;
                        unique case (t_mode'(i_req.mode))
                            MODE_APPEND: begin
                                if (full) begin
                                    r_res <= f_rsp(ST_FULL, '0, '0, 1'b1);
                                end else begin
                                    if (r_rev) begin
                                        r_head <= head_dec;
                                    end
                                    r_count <= r_count + CW'(1);
                                    r_res   <= f_rsp(ST_APPENDED, '0, '0, 1'b1);
                                end
                                r_state <= S_EMIT;
                            end
                            MODE_REMOVE: begin
                                if (empty) begin
                                    r_res   <= f_rsp(ST_EMPTY, '0, '0, 1'b1);
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= S_POP;
                                end
                            end
                            MODE_REVERSE: begin
                                r_rev   <= !r_rev;
                                r_res   <= f_rsp(ST_REVERSED, '0, '0, 1'b1);
                                r_state <= S_EMIT;
                            end
                            MODE_SEARCH: begin
                                r_rd_pos  <= '0;
                                r_cmp_vld <= 1'b0;
                                r_pend    <= 1'b0;
                                if (empty) begin
                                    r_res   <= f_rsp(ST_NOTFOUND, '0, '0, 1'b1);
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_POP: begin
                    r_res <= f_rsp(ST_POPPED, mem_rdata, '0, 1'b1);
                    if (r_rev) begin
                        r_head <= head_inc;
                    end
                    r_count <= r_count - CW'(1);
                    r_state <= S_EMIT;
                end
                S_SCAN: begin
                    if (!stall) begin
                        r_cmp_vld <= more;
                        r_cmp_pos <= r_rd_pos;
                        if (more) begin
                            r_rd_pos <= r_rd_pos + CW'(1);
                        end
                        if (cmp_hit) begin
                            r_pend     <= 1'b1;
                            r_pend_pos <= r_cmp_pos + CW'(1);
                        end
                        if (scan_done) begin
                            r_res   <= r_pend ? f_rsp(ST_FOUND, '0, POS_W'(r_pend_pos), 1'b1)
                                              : f_rsp(ST_NOTFOUND, '0, '0, 1'b1);
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_can_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    blrs_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    blrs_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (out_load),
        .i_data     (out_data),
        .o_can_load (out_can_load),
        .o_rsp      (o_rsp)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("item count above depth");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_req.mode == MODE_APPEND) && !full)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("append did not grow the list");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && r_cmp_vld) |-> (r_cmp_pos < r_count))
        else $error("search compared outside the list");

    a_empty_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_req.mode == MODE_SEARCH) && empty)
        |=> ((r_state == S_EMIT) && (r_res.status == ST_NOTFOUND)))
        else $error("search of empty list not reported as not found");

endmodule
